FILE: design/clcq_pkg.sv
// ----------------------------------------------------------------------------
// clcq_pkg
// Shared widths and types for the paced character LCD command queue.
// ----------------------------------------------------------------------------
package clcq_pkg;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 32;  // value, column, row, bus_ready, zero fill
    localparam int S_TUSER_W  = 3;   // func
    localparam int M_TDATA_W  = 16;  // expander_byte, target_address
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int WORD_W = 10;      // backlight, register select, byte

    // request kinds carried in s_axis_tuser, the last two are ignored
    typedef enum logic [S_TUSER_W-1:0] {
        FUNC_CMD    = 3'd0,
        FUNC_DATA   = 3'd1,
        FUNC_CURSOR = 3'd2,
        FUNC_TICK   = 3'd3,
        FUNC_DONE   = 3'd4,
        FUNC_POLL   = 3'd5,
        FUNC_RSVD6  = 3'd6,
        FUNC_RSVD7  = 3'd7
    } t_func;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

    // request from the sequencer to the word store
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WORD_W-1:0] wdata;
    } t_fifo_ctrl;

    // status from the word store
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

FILE: design/clcq_fifo.sv
// ----------------------------------------------------------------------------
// clcq_fifo
// Word store: synchronous memory with head and tail pointers and a fill count.
// ----------------------------------------------------------------------------
module clcq_fifo
    import clcq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_ctrl        i_ctrl,
    output t_fifo_stat        o_stat,
    output logic [WORD_W-1:0] o_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic              w_full, w_empty, w_wr, w_rd;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    // a push into a full store is dropped
    assign w_wr    = i_ctrl.push & ~w_full;
    assign w_rd    = i_ctrl.pop & ~w_empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_wr) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (w_rd) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_tail] <= i_ctrl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;
    assign o_rd_data    = r_rd_data;

endmodule

FILE: design/char_lcd_paced_command_queue_top.sv
// ----------------------------------------------------------------------------
// char_lcd_paced_command_queue_top
// Queues LCD commands, data and cursor moves and paces them out as
// 4-bit expander bytes.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one transaction per request. tuser carries the
// request kind (queue command, queue data, queue cursor, ms tick, transfer
// done, poll); tdata carries value, column, row and bus_ready.
// Output stream (m_axis): a granted poll yields four transactions, each an
// expander byte with the device address; tlast marks the fourth.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 backlight, 1 minimum gap in ms, 2 device address).
// Timing: every request except a granted poll leaves the input ready. A granted
// poll reads the word store (a registered read, state ST_READ), then
// presents the four bytes in turn; input is held off until
// the last byte is taken. A stall on m_axis holds the current byte and
// holds off the input. Reset empties the queue, saturates the ms counter
// and loads the register defaults; the word store itself is not cleared.
// ----------------------------------------------------------------------------
module char_lcd_paced_command_queue_top
    import clcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // value, column, row, bus_ready
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // expander_byte, target_address
    output logic                  m_axis_tlast    // last_byte
);

    localparam logic [8:0] CURSOR_LIMIT = 9'd80;
    localparam logic [7:0] SET_DDRAM    = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_beat, n_beat;
    logic [7:0]  r_elapsed;
    logic        r_backlight;
    logic [7:0]  r_min_gap;
    logic [7:0]  r_dev_addr;

    t_fifo_ctrl        w_ctrl;
    t_fifo_stat        w_stat;
    logic [WORD_W-1:0] w_word;

    logic       w_accept, w_grant, w_push, w_sel, w_bus_ready, w_out_take;
    logic [2:0] w_func;
    logic [7:0] w_value, w_column, w_row, w_byte;
    logic [6:0] w_offset;
    logic [8:0] w_pos;
    logic [3:0] w_nib;

    assign w_func      = s_axis_tuser;
    assign w_value     = s_axis_tdata[7:0];
    assign w_column    = s_axis_tdata[15:8];
    assign w_row       = s_axis_tdata[23:16];
    assign w_bus_ready = s_axis_tdata[24];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_out_take    = m_axis_tvalid & m_axis_tready;

    // DDRAM row offsets, rows above 3 fall back to the first row
    always_comb begin
        case (w_row)
            8'd1:    w_offset = 7'd40;
            8'd2:    w_offset = 7'd20;
            8'd3:    w_offset = 7'd60;
            default: w_offset = 7'd0;
        endcase
    end

    assign w_pos = {1'b0, w_column} + {2'b00, w_offset};

    always_comb begin
        w_push = 1'b0;
        w_sel  = 1'b0;
        w_byte = w_value;
        case (w_func)
            FUNC_CMD:    w_push = 1'b1;
            FUNC_DATA: begin
                w_push = 1'b1;
                w_sel  = 1'b1;
            end
            FUNC_CURSOR: begin
                w_push = (w_pos < CURSOR_LIMIT);
                w_byte = w_pos[7:0] | SET_DDRAM;
            end
            default:     w_push = 1'b0;
        endcase
    end

    assign w_grant = w_accept & (w_func == FUNC_POLL) & w_bus_ready
                   & (r_elapsed >= r_min_gap) & ~w_stat.empty;

    assign w_ctrl.push  = w_accept & w_push;
    assign w_ctrl.pop   = w_grant;
    assign w_ctrl.wdata = {r_backlight, w_sel, w_byte};

    clcq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .o_stat    (w_stat),
        .o_rd_data (w_word)
    );

    always_comb begin
        n_state = r_state;
        n_beat  = r_beat;
        case (r_state)
            ST_IDLE: begin
                if (w_grant) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_SEND;
                n_beat  = 2'd0;
            end
            ST_SEND: begin
                if (w_out_take) begin
                    n_beat = r_beat + 1'b1;
                    if (r_beat == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_beat  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_beat  <= n_beat;
        end
    end

    // ms counter saturates, transfer done clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= 8'hFF;
        end else if (w_accept && w_func == FUNC_TICK && r_elapsed != 8'hFF) begin
            r_elapsed <= r_elapsed + 1'b1;
        end else if (w_accept && w_func == FUNC_DONE) begin
            r_elapsed <= 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b1;
            r_min_gap   <= 8'd5;
            r_dev_addr  <= 8'd78;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BACKLIGHT: r_backlight <= i_cfg_data[0];
                CFG_MIN_GAP:   r_min_gap   <= i_cfg_data;
                CFG_DEV_ADDR:  r_dev_addr  <= i_cfg_data;
                default:       r_backlight <= r_backlight;
            endcase
        end
    end

    // high nibble first, enable strobed on even beats
    assign w_nib = r_beat[1] ? w_word[3:0] : w_word[7:4];

    assign m_axis_tvalid = (r_state == ST_SEND);
    assign m_axis_tdata  = {r_dev_addr, w_nib, w_word[9], ~r_beat[0], 1'b0, w_word[8]};
    assign m_axis_tlast  = (r_beat == 2'd3);

endmodule

FILE: design/clcq_checker.sv
// ----------------------------------------------------------------------------
// clcq_checker
// Port-level checks for the paced LCD command queue, bound to the top level.
// ----------------------------------------------------------------------------
module clcq_checker
    import clcq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // a stalled byte holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    // input is held off while a run is going out
    a_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during output run");

    // the four bytes of a run follow without gaps
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside output run");

    // enable strobe drops on the byte after it was sent
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[2] |=>
            m_axis_tvalid && !m_axis_tdata[2] && !m_axis_tdata[1])
        else $error("enable strobe not followed by release");

endmodule

bind char_lcd_paced_command_queue_top clcq_checker u_clcq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/tb_char_lcd_paced_command_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_paced_command_queue_top
// Self-checking bench for the paced LCD command queue. A short directed
// script is run first, then random request mixes under several register
// settings. Every request is fed to a local predictor of the queue, ms
// counter and nibble split, and each expander byte is checked on arrival.
// ----------------------------------------------------------------------------
module tb_char_lcd_paced_command_queue_top
    import clcq_pkg::*;
();

    localparam int WORD_SLOTS  = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 12;
    localparam logic [7:0] DEFAULT_ADDR = 8'd78;

    typedef enum {MIX_ALL, MIX_QUEUE_ONLY, MIX_NO_DONE} t_mix;

    typedef struct packed {
        t_func      func;
        logic [7:0] value;
        logic [7:0] column;
        logic [7:0] row;
        logic       bus_ready;
    } t_lcd_req;

    typedef struct packed {
        logic [7:0] xbyte;
        logic [7:0] addr;
        logic       last;
    } t_lcd_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // value, column, row, bus_ready
    logic [S_TUSER_W-1:0]  s_axis_tuser;   // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // expander_byte, target_address
    logic                  m_axis_tlast;   // last_byte

    // predictor state
    logic [WORD_W-1:0] word_fifo[$];
    logic [7:0]        elapsed_q = 8'hFF;
    logic              backlight_q = 1'b1;
    logic [7:0]        min_gap_q = 8'd5;
    logic [7:0]        dev_addr_q = DEFAULT_ADDR;

    t_lcd_out    expander_due[$];
    int          fail_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    // directed script
    t_lcd_req    script_req[$];
    bit          script_typed[$];
    logic [31:0] script_bytes[$];

    char_lcd_paced_command_queue_top #(
        .QUEUE_DEPTH (WORD_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_char_lcd_paced_command_queue_top NOT OK");
            $finish;
        end
    end

    task automatic queue_word(input logic sel, input logic [7:0] byte_val);
        begin
            if (word_fifo.size() < WORD_SLOTS)
                word_fifo.push_back({backlight_q, sel, byte_val});
        end
    endtask

    task automatic lcd_predict(input t_lcd_req q, output int n, output t_lcd_out [3:0] res);
        logic [8:0]        pos;
        logic [WORD_W-1:0] w;
        logic [3:0]        nib;
        begin
            n = 0;
            res = '0;
            case (q.func)
                FUNC_CMD:  queue_word(1'b0, q.value);
                FUNC_DATA: queue_word(1'b1, q.value);
                FUNC_CURSOR: begin
                    // sum kept at full width, no wrap past 255
                    pos = {1'b0, q.column};
                    case (q.row)
                        8'd1: pos = pos + 9'd40;
                        8'd2: pos = pos + 9'd20;
                        8'd3: pos = pos + 9'd60;
                        default: ;
                    endcase
                    if (pos < 9'd80)
                        queue_word(1'b0, pos[7:0] | 8'h80);
                end
                FUNC_TICK: begin
                    if (elapsed_q != 8'hFF)
                        elapsed_q = elapsed_q + 8'd1;
                end
                FUNC_DONE: elapsed_q = 8'd0;
                FUNC_POLL: begin
                    if (q.bus_ready && elapsed_q >= min_gap_q && word_fifo.size() != 0) begin
                        w = word_fifo.pop_front();
                        n = 4;
                        for (int k = 0; k < 4; k++) begin
                            nib = (k < 2) ? w[7:4] : w[3:0];
                            res[k].xbyte = {nib, w[9], (k % 2 == 0), 1'b0, w[8]};
                            res[k].addr  = dev_addr_q;
                            res[k].last  = (k == 3);
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    function automatic t_lcd_req rand_req(input t_mix mix);
        t_lcd_req q;
        int       pick;
        begin
            q.value     = 8'($urandom_range(0, 255));
            q.column    = 8'($urandom_range(0, 255));
            q.row       = 8'($urandom_range(0, 255));
            q.bus_ready = ($urandom_range(0, 4) != 0);
            pick = (mix == MIX_QUEUE_ONLY) ? $urandom_range(0, 44) : $urandom_range(0, 99);
            if (pick < 15)
                q.func = FUNC_CMD;
            else if (pick < 30)
                q.func = FUNC_DATA;
            else if (pick < 45) begin
                q.func = FUNC_CURSOR;
                // mostly positions that land on the display
                if ($urandom_range(0, 3) != 0) begin
                    q.row    = 8'($urandom_range(0, 3));
                    q.column = 8'($urandom_range(0, 45));
                end
            end else if (pick < 65)
                q.func = FUNC_TICK;
            else if (pick < 70)
                q.func = (mix == MIX_NO_DONE) ? FUNC_TICK : FUNC_DONE;
            else if (pick < 97)
                q.func = FUNC_POLL;
            else
                q.func = ($urandom_range(0, 1) != 0) ? FUNC_RSVD6 : FUNC_RSVD7;
            return q;
        end
    endfunction

    function automatic t_lcd_req rand_of(input t_func f);
        t_lcd_req q;
        begin
            q = rand_req(MIX_ALL);
            q.func = f;
            q.bus_ready = 1'b1;
            return q;
        end
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_req(input t_lcd_req q, input bit typed, input logic [31:0] typed_bytes);
        int             n;
        t_lcd_out [3:0] res;
        t_lcd_out       o;
        begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(S_TDATA_W-25){1'b0}}, q.bus_ready, q.row, q.column, q.value};
            s_axis_tuser  <= q.func;
            do @(posedge i_clk); while (!s_axis_tready);
            lcd_predict(q, n, res);
            if (typed) begin
                for (int k = 0; k < 4; k++) begin
                    o.xbyte = typed_bytes[8*k +: 8];
                    o.addr  = DEFAULT_ADDR;
                    o.last  = (k == 3);
                    expander_due.push_back(o);
                end
            end else begin
                for (int k = 0; k < n; k++)
                    expander_due.push_back(res[k]);
            end
            @(negedge i_clk);
        end
    endtask

    task automatic stop_and_drain;
        begin
            s_axis_tvalid <= 1'b0;
            while (expander_due.size() != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            case (idx)
                CFG_BACKLIGHT: backlight_q = data[0];
                CFG_MIN_GAP:   min_gap_q = data;
                CFG_DEV_ADDR:  dev_addr_q = data;
                default: ;
            endcase
            @(negedge i_clk);
        end
    endtask

    task automatic script_row(input t_func f, input logic [7:0] v, input logic [7:0] c,
                              input logic [7:0] r, input logic br, input bit typed,
                              input logic [31:0] bytes);
        t_lcd_req q;
        begin
            q.func = f;
            q.value = v;
            q.column = c;
            q.row = r;
            q.bus_ready = br;
            script_req.push_back(q);
            script_typed.push_back(typed);
            script_bytes.push_back(bytes);
        end
    endtask

    // output side: short random stalls, plus one long hold on request
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_lcd_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expander_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, %s %h addr %h last %b",
                         $time, "actual byte", m_axis_tdata[7:0], m_axis_tdata[15:8],
                         m_axis_tlast);
                fail_cnt++;
            end else begin
                want = expander_due.pop_front();
                if (m_axis_tdata[7:0] !== want.xbyte) begin
                    $display("%0t: expander byte, expected %h actual %h",
                             $time, want.xbyte, m_axis_tdata[7:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[15:8] !== want.addr) begin
                    $display("%0t: target address, expected %h actual %h",
                             $time, want.addr, m_axis_tdata[15:8]);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last byte, expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: backlight on, 5 ms gap, address 78, counter saturated
        script_row(FUNC_TICK,   8'h00, 8'd0,   8'd0,   1'b1, 1'b0, 32'h0);
        script_row(FUNC_POLL,   8'h00, 8'd0,   8'd0,   1'b1, 1'b0, 32'h0);
        script_row(FUNC_CMD,    8'hFF, 8'd0,   8'd0,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_POLL,   8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 32'hF8FCF8FC);
        script_row(FUNC_DATA,   8'h00, 8'd0,   8'd0,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_POLL,   8'h00, 8'd0,   8'd0,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_POLL,   8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 32'h090D090D);
        script_row(FUNC_DONE,   8'h00, 8'd0,   8'd0,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_CMD,    8'hA5, 8'd0,   8'd0,   1'b0, 1'b0, 32'h0);
        // gap not yet elapsed
        script_row(FUNC_POLL,   8'h00, 8'd0,   8'd0,   1'b1, 1'b0, 32'h0);
        repeat (5)
            script_row(FUNC_TICK, 8'h00, 8'd0, 8'd0,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_POLL,   8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 32'h585CA8AC);
        script_row(FUNC_CURSOR, 8'h00, 8'd0,   8'd0,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_CURSOR, 8'h00, 8'd19,  8'd3,   1'b0, 1'b0, 32'h0);
        // off the display: dropped
        script_row(FUNC_CURSOR, 8'h00, 8'd20,  8'd3,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_CURSOR, 8'h00, 8'd255, 8'd255, 1'b0, 1'b0, 32'h0);
        script_row(FUNC_CURSOR, 8'h00, 8'd39,  8'd1,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_CURSOR, 8'h00, 8'd5,   8'd2,   1'b0, 1'b0, 32'h0);
        script_row(FUNC_RSVD6,  8'hFF, 8'hFF,  8'hFF,  1'b1, 1'b0, 32'h0);
        script_row(FUNC_RSVD7,  8'hFF, 8'hFF,  8'hFF,  1'b1, 1'b0, 32'h0);
        script_row(FUNC_POLL,   8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 32'h080C888C);
        for (int i = 0; i < script_req.size(); i++)
            send_req(script_req[i], script_typed[i], script_bytes[i]);
        stop_and_drain;

        // backlight takes bit 0 only; no gap; top address
        write_reg(CFG_BACKLIGHT, 8'hFE);
        write_reg(CFG_MIN_GAP, 8'd0);
        write_reg(CFG_DEV_ADDR, 8'hFF);
        write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
        repeat (50) send_req(rand_req(MIX_ALL), 1'b0, 32'h0);
        stop_and_drain;

        // queue requests meant to fill the queue, then a poll one tick short of the gap
        write_reg(CFG_BACKLIGHT, 8'h01);
        write_reg(CFG_MIN_GAP, 8'd40);
        write_reg(CFG_DEV_ADDR, 8'h00);
        repeat (150) send_req(rand_req(MIX_QUEUE_ONLY), 1'b0, 32'h0);
        send_req(rand_of(FUNC_DONE), 1'b0, 32'h0);
        repeat (39) send_req(rand_of(FUNC_TICK), 1'b0, 32'h0);
        send_req(rand_of(FUNC_POLL), 1'b0, 32'h0);
        send_req(rand_of(FUNC_TICK), 1'b0, 32'h0);
        send_req(rand_of(FUNC_TICK), 1'b0, 32'h0);
        // output blocked for a long stretch while polls keep coming
        hold_req = 1'b1;
        repeat (30) send_req(rand_req(MIX_NO_DONE), 1'b0, 32'h0);
        stop_and_drain;

        write_reg(CFG_BACKLIGHT, 8'($urandom_range(0, 255)));
        write_reg(CFG_MIN_GAP, 8'($urandom_range(1, 8)));
        write_reg(CFG_DEV_ADDR, 8'($urandom_range(0, 255)));
        repeat (40) send_req(rand_req(MIX_ALL), 1'b0, 32'h0);
        // input paused until every byte is out
        stop_and_drain;
        repeat (40) send_req(rand_req(MIX_ALL), 1'b0, 32'h0);
        stop_and_drain;

        calm = 1'b1;
        // let any receiver stall run out
        repeat (20) @(negedge i_clk);
        write_reg(CFG_BACKLIGHT, 8'h01);
        write_reg(CFG_MIN_GAP, 8'd2);
        write_reg(CFG_DEV_ADDR, DEFAULT_ADDR);
        repeat (30) send_req(rand_req(MIX_ALL), 1'b0, 32'h0);
        stop_and_drain;

        if (fail_cnt == 0)
            $display("tb_char_lcd_paced_command_queue_top OK");
        else
            $display("tb_char_lcd_paced_command_queue_top NOT OK");
        $finish;
    end

endmodule
